>>> sv/ddpu_pkg.sv
// ---------------------------------------------------------------------------
// ddpu_pkg
// Shared types, constants and tables for the differential drive pose update.
// ---------------------------------------------------------------------------
package ddpu_pkg;

   localparam int VEL_W        = 16;
   localparam int MS_W         = 10;
   localparam int LEN_W        = 16;
   localparam int POS_W        = 32;
   localparam int ANG_W        = 16;
   localparam int P1_W         = 28;
   localparam int P2_W         = 44;
   localparam int DIV_NUM_W    = 43;
   localparam int DIST_DEN_W   = 21;
   localparam int V_W          = 23;
   localparam int CRD_W        = 34;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = 5;
   localparam int ATAN_W       = 30;
   localparam int K_W          = 25;

   localparam int DIST_SHIFT    = 14;
   localparam int DIST_N_W      = DIV_NUM_W - DIST_SHIFT;
   localparam int DIST_RECIP_W  = 30;
   localparam int DIST_RECIP_SH = 36;
   localparam int DIST_Q_W      = 22;

   localparam int CORDIC_ITERATIONS_DEF = 16;

   localparam logic [K_W-1:0]          ANGLE_K    = 25'd21874089;
   localparam logic [CRD_W-1:0]        CORDIC_X0  = 34'd652032874;
   localparam logic [DIST_DEN_W-1:0]   DIST_DEN   = 21'd2048000;
   localparam logic [DIV_NUM_W-1:0]    DIST_HALF  = 43'd1024000;
   localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 30'd549755814;

   localparam logic [LEN_W-1:0] RADIUS_RESET = 16'd1343;
   localparam logic [LEN_W-1:0] AXLE_RESET   = 16'd3408;

   localparam logic REG_WHEEL_RADIUS = 1'b0;
   localparam logic REG_AXLE_LENGTH  = 1'b1;

   typedef struct packed {
      logic capture;
      logic mul1;
      logic mul2;
      logic div_start;
      logic ang_lo;
      logic ang_hi;
      logic ang_d;
      logic cordic_start;
      logic mul_xy;
      logic commit;
   } ddpu_cmd_type;

   typedef struct packed {
      logic div_done;
      logic cordic_done;
   } ddpu_status_type;

   function automatic logic [ATAN_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:    val = 30'd536870912;
         5'd1:    val = 30'd316933406;
         5'd2:    val = 30'd167458907;
         5'd3:    val = 30'd85004756;
         5'd4:    val = 30'd42667331;
         5'd5:    val = 30'd21354465;
         5'd6:    val = 30'd10679838;
         5'd7:    val = 30'd5340245;
         5'd8:    val = 30'd2670163;
         5'd9:    val = 30'd1335087;
         5'd10:   val = 30'd667544;
         5'd11:   val = 30'd333772;
         5'd12:   val = 30'd166886;
         5'd13:   val = 30'd83443;
         5'd14:   val = 30'd41722;
         5'd15:   val = 30'd20861;
         5'd16:   val = 30'd10430;
         5'd17:   val = 30'd5215;
         5'd18:   val = 30'd2608;
         5'd19:   val = 30'd1304;
         5'd20:   val = 30'd652;
         5'd21:   val = 30'd326;
         5'd22:   val = 30'd163;
         5'd23:   val = 30'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> sv/ddpu_divider.sv
// ---------------------------------------------------------------------------
// ddpu_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ddpu_divider #(
   parameter int NUM_W = ddpu_pkg::DIV_NUM_W,
   parameter int DEN_W = ddpu_pkg::LEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fit;

   always_comb begin
      trial  = {rem_ff, acc_ff[NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      fit    = !diff[DEN_W];
      acc_in = acc_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         acc_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         acc_in = {acc_ff[NUM_W-2:0], fit};
         rem_in = fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = (cnt_ff == '0);
   assign quot = acc_ff;

endmodule

>>> sv/ddpu_cordic.sv
// ---------------------------------------------------------------------------
// ddpu_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
module ddpu_cordic #(
   parameter int CORDIC_ITERATIONS = ddpu_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ddpu_pkg::ANG_W-1:0]          angle,
   output logic                                done,
   output logic signed [ddpu_pkg::CRD_W-1:0]   cos_out,
   output logic signed [ddpu_pkg::CRD_W-1:0]   sin_out
);

   localparam int CNT_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam int W     = ddpu_pkg::CRD_W;

   logic signed [W-1:0] x_ff, x_in;
   logic signed [W-1:0] y_ff, y_in;
   logic signed [W-1:0] z_ff, z_in;
   logic                flip_ff, flip_in;
   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic signed [W-1:0] xs, ys, at;
   logic                flip;
   logic [ddpu_pkg::ANG_W-1:0] turn;

   always_comb begin
      flip    = angle[15] ^ angle[14];
      turn    = angle ^ {flip, 15'd0};
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      at      = W'(ddpu_pkg::atan_turns(ddpu_pkg::ATAN_IDX_W'(cnt_ff)));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         x_in    = ddpu_pkg::CORDIC_X0;
         y_in    = '0;
         z_in    = {{(W-32){turn[15]}}, turn, 16'd0};
         flip_in = flip;
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!z_ff[W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CORDIC_ITERATIONS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cnt_ff  <= cnt_in;
   end

   assign done    = !busy_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

>>> sv/ddpu_datapath.sv
// ---------------------------------------------------------------------------
// ddpu_datapath
// Pose registers, products, divider, CORDIC and saturating position update.
// ---------------------------------------------------------------------------
module ddpu_datapath #(
   parameter int CORDIC_ITERATIONS = ddpu_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ddpu_pkg::ddpu_cmd_type                cmd,
   output ddpu_pkg::ddpu_status_type             status,
   input  logic signed [ddpu_pkg::VEL_W-1:0]     left_velocity,
   input  logic signed [ddpu_pkg::VEL_W-1:0]     right_velocity,
   input  logic        [ddpu_pkg::MS_W-1:0]      step_ms,
   input  logic        [ddpu_pkg::LEN_W-1:0]     wheel_radius,
   input  logic        [ddpu_pkg::LEN_W-1:0]     axle_length,
   output logic signed [ddpu_pkg::POS_W-1:0]     pose_x,
   output logic signed [ddpu_pkg::POS_W-1:0]     pose_y,
   output logic        [ddpu_pkg::ANG_W-1:0]     pose_heading
);

   localparam int NW = ddpu_pkg::DIV_NUM_W;
   localparam int LW = ddpu_pkg::LEN_W;
   localparam int PW = 57;
   localparam int VPW = ddpu_pkg::DIST_N_W + ddpu_pkg::DIST_RECIP_W;

   logic signed [ddpu_pkg::VEL_W-1:0] vl_ff, vr_ff;
   logic        [ddpu_pkg::MS_W-1:0]  ms_ff;
   logic signed [ddpu_pkg::P1_W-1:0]  p1d_ff, p1s_ff;
   logic signed [ddpu_pkg::P2_W-1:0]  p2d_ff, p2s_ff;
   logic                              negd_ff, negs_ff;
   logic signed [16:0]                diff, sum;
   logic signed [ddpu_pkg::P1_W-1:0]  p1d_in, p1s_in;
   logic signed [ddpu_pkg::P2_W-1:0]  p2d_in, p2s_in;
   logic [NW-1:0]                     magd, mags, numd, nums;
   logic [LW-1:0]                     axle_eff;
   logic [NW-1:0]                     quot_d;
   logic                              done_d;
   logic [ddpu_pkg::DIST_N_W-1:0]     vn_ff;
   logic [VPW-1:0]                    vprod;
   logic [ddpu_pkg::DIST_Q_W-1:0]     vq;
   logic [47:0]                       q48;
   logic [48:0]                       pa_ff, pa_in, pb_full;
   logic [23:0]                       pb_ff;
   logic [47:0]                       u;
   logic [ddpu_pkg::ANG_W-1:0]        d_ff;
   logic signed [ddpu_pkg::V_W-1:0]   v_ff, v_in;
   logic signed [ddpu_pkg::CRD_W-1:0] cos_val, sin_val;
   logic                              crd_done;
   logic signed [PW-1:0]              px_ff, py_ff, px_in, py_in, rx, ry;
   logic signed [33:0]                sx, sy;
   logic signed [ddpu_pkg::POS_W-1:0] x_ff, y_ff, x_in, y_in;
   logic [ddpu_pkg::ANG_W-1:0]        h_ff;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
      logic signed [31:0] r;
      if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
         r = s[31:0];
      end else if (s[33]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   always_comb begin
      diff     = {vr_ff[15], vr_ff} - {vl_ff[15], vl_ff};
      sum      = {vr_ff[15], vr_ff} + {vl_ff[15], vl_ff};
      p1d_in   = diff * $signed({1'b0, ms_ff});
      p1s_in   = sum * $signed({1'b0, ms_ff});
      p2d_in   = p1d_ff * $signed({1'b0, wheel_radius});
      p2s_in   = p1s_ff * $signed({1'b0, wheel_radius});
      axle_eff = (axle_length == '0) ? LW'(1) : axle_length;
      magd     = p2d_ff[ddpu_pkg::P2_W-1] ? NW'(-p2d_ff) : NW'(p2d_ff);
      mags     = p2s_ff[ddpu_pkg::P2_W-1] ? NW'(-p2s_ff) : NW'(p2s_ff);
      numd     = magd + NW'(axle_eff >> 1);
      nums     = mags + ddpu_pkg::DIST_HALF;
      vprod    = vn_ff * ddpu_pkg::DIST_RECIP;
      vq       = ddpu_pkg::DIST_Q_W'(vprod >> ddpu_pkg::DIST_RECIP_SH);
      q48      = negd_ff ? 48'(-{5'd0, quot_d}) : {5'd0, quot_d};
      pa_in    = q48[23:0] * ddpu_pkg::ANGLE_K;
      pb_full  = q48[47:24] * ddpu_pkg::ANGLE_K;
      u        = pa_ff[47:0] + {pb_ff, 24'd0} + 48'h0000_8000_0000;
      v_in     = negs_ff ? -$signed({1'b0, vq}) : $signed({1'b0, vq});
      px_in    = v_ff * cos_val;
      py_in    = v_ff * sin_val;
      rx       = px_ff + PW'(64'sd536870912);
      ry       = py_ff + PW'(64'sd536870912);
      sx       = {{2{x_ff[31]}}, x_ff} + 34'(rx >>> 30);
      sy       = {{2{y_ff[31]}}, y_ff} + 34'(ry >>> 30);
      x_in     = sat32(sx);
      y_in     = sat32(sy);
   end

   ddpu_divider #(.NUM_W(NW), .DEN_W(LW)) u_div_angle (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (numd),
      .den   (axle_eff),
      .done  (done_d),
      .quot  (quot_d)
   );

   ddpu_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.cordic_start),
      .angle   (h_ff + d_ff),
      .done    (crd_done),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         h_ff <= '0;
      end else if (cmd.commit) begin
         x_ff <= x_in;
         y_ff <= y_in;
         h_ff <= h_ff + {d_ff[14:0], 1'b0};
      end
      if (cmd.capture) begin
         vl_ff <= left_velocity;
         vr_ff <= right_velocity;
         ms_ff <= step_ms;
      end
      if (cmd.mul1) begin
         p1d_ff <= p1d_in;
         p1s_ff <= p1s_in;
      end
      if (cmd.mul2) begin
         p2d_ff <= p2d_in;
         p2s_ff <= p2s_in;
      end
      if (cmd.div_start) begin
         negd_ff <= p2d_ff[ddpu_pkg::P2_W-1];
         negs_ff <= p2s_ff[ddpu_pkg::P2_W-1];
         vn_ff   <= nums[NW-1:ddpu_pkg::DIST_SHIFT];
      end
      if (cmd.ang_lo) begin
         pa_ff <= pa_in;
         v_ff  <= v_in;
      end
      if (cmd.ang_hi) begin
         pb_ff <= pb_full[23:0];
      end
      if (cmd.ang_d) begin
         d_ff <= u[47:32];
      end
      if (cmd.mul_xy) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign status.div_done    = done_d;
   assign status.cordic_done = crd_done;
   assign pose_x             = x_ff;
   assign pose_y             = y_ff;
   assign pose_heading       = h_ff;

endmodule

>>> sv/ddpu_controller.sv
// ---------------------------------------------------------------------------
// ddpu_controller
// Sequencer for one transaction and the result valid flag.
// ---------------------------------------------------------------------------
module ddpu_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ddpu_pkg::ddpu_cmd_type    cmd,
   input  ddpu_pkg::ddpu_status_type status
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL1   = 4'd1;
   localparam logic [3:0] ST_MUL2   = 4'd2;
   localparam logic [3:0] ST_DIVS   = 4'd3;
   localparam logic [3:0] ST_DIVW   = 4'd4;
   localparam logic [3:0] ST_ANGL   = 4'd5;
   localparam logic [3:0] ST_ANGH   = 4'd6;
   localparam logic [3:0] ST_ANGD   = 4'd7;
   localparam logic [3:0] ST_CRDS   = 4'd8;
   localparam logic [3:0] ST_CRDW   = 4'd9;
   localparam logic [3:0] ST_MULXY  = 4'd10;
   localparam logic [3:0] ST_COMMIT = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      cmd      = '0;
      state_in = state_ff;
      valid_in = valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (status.div_done) begin
               state_in = ST_ANGL;
            end
         end
         ST_ANGL: begin
            cmd.ang_lo = 1'b1;
            state_in   = ST_ANGH;
         end
         ST_ANGH: begin
            cmd.ang_hi = 1'b1;
            state_in   = ST_ANGD;
         end
         ST_ANGD: begin
            cmd.ang_d = 1'b1;
            state_in  = ST_CRDS;
         end
         ST_CRDS: begin
            cmd.cordic_start = 1'b1;
            state_in         = ST_CRDW;
         end
         ST_CRDW: begin
            if (status.cordic_done) begin
               state_in = ST_MULXY;
            end
         end
         ST_MULXY: begin
            cmd.mul_xy = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

>>> sv/differential_drive_pose_update_core.sv
// ---------------------------------------------------------------------------
// differential_drive_pose_update_core
// Midpoint odometry pose update with an iterative divider and CORDIC.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall left/right velocity, step_ms
//   rsp      out        rsp_valid/rsp_stall x, y, heading
//   csr      in         APB psel/penable    wheel_radius, axle_length
//
// A result appears and the input reopens in the same cycle; the bit-serial
// divide by the axle length and the CORDIC loop dominate a transaction.
// Synchronous active-high reset clears the pose and loads register defaults.
// A new transaction is accepted while a result waits; if the result is
// still stalled when the next update is ready, the update holds.
// ---------------------------------------------------------------------------
module differential_drive_pose_update_core #(
   parameter int CORDIC_ITERATIONS = ddpu_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ddpu_pkg::VEL_W-1:0]   req_left_velocity,
   input  logic signed [ddpu_pkg::VEL_W-1:0]   req_right_velocity,
   input  logic        [ddpu_pkg::MS_W-1:0]    req_step_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ddpu_pkg::POS_W-1:0]   rsp_out_x,
   output logic signed [ddpu_pkg::POS_W-1:0]   rsp_out_y,
   output logic        [ddpu_pkg::ANG_W-1:0]   rsp_out_heading,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [ddpu_pkg::LEN_W-1:0] radius_ff, axle_ff;
   logic                       wr_en;
   ddpu_pkg::ddpu_cmd_type     cmd;
   ddpu_pkg::ddpu_status_type  status;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ddpu_pkg::RADIUS_RESET;
         axle_ff   <= ddpu_pkg::AXLE_RESET;
      end else if (wr_en) begin
         unique case (paddr[2])
            ddpu_pkg::REG_WHEEL_RADIUS: radius_ff <= pwdata[15:0];
            ddpu_pkg::REG_AXLE_LENGTH:  axle_ff   <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         ddpu_pkg::REG_WHEEL_RADIUS: prdata = {16'd0, radius_ff};
         ddpu_pkg::REG_AXLE_LENGTH:  prdata = {16'd0, axle_ff};
         default:                    prdata = '0;
      endcase
   end

   ddpu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ddpu_datapath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .left_velocity  (req_left_velocity),
      .right_velocity (req_right_velocity),
      .step_ms        (req_step_ms),
      .wheel_radius   (radius_ff),
      .axle_length    (axle_ff),
      .pose_x         (rsp_out_x),
      .pose_y         (rsp_out_y),
      .pose_heading   (rsp_out_heading)
   );

endmodule

>>> sv/ddpu_checker.sv
// ---------------------------------------------------------------------------
// ddpu_checker
// Port-level checks for the pose update core, attached by bind.
// ---------------------------------------------------------------------------
module ddpu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_x,
   input logic [31:0] rsp_out_y,
   input logic [15:0] rsp_out_heading
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request not stalled after transaction accepted");

   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a transaction in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_heading))
      else $error("stalled result changed");

endmodule

bind differential_drive_pose_update_core ddpu_checker u_ddpu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_out_heading (rsp_out_heading)
);

>>> bench/differential_drive_pose_update_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// differential_drive_pose_update_core_tb
// Drives wheel velocity steps into the pose update core under several
// valid/stall patterns and register settings, predicts each pose with an
// independent fixed-point odometry model and compares every result field.
// ---------------------------------------------------------------------------
module differential_drive_pose_update_core_tb;

   typedef struct {
      logic signed [ddpu_pkg::POS_W-1:0] x;
      logic signed [ddpu_pkg::POS_W-1:0] y;
      logic [ddpu_pkg::ANG_W-1:0]        heading;
   } pose_type;

   localparam int ITER_COUNT = ddpu_pkg::CORDIC_ITERATIONS_DEF;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [2:0] ADDR_RADIUS = 3'd0;
   localparam logic [2:0] ADDR_AXLE = 3'd4;

   class pose_scoreboard;
      pose_type expected_poses[$];
      logic [ddpu_pkg::LEN_W-1:0] radius;
      logic [ddpu_pkg::LEN_W-1:0] axle;
      logic signed [ddpu_pkg::POS_W-1:0] pos_x;
      logic signed [ddpu_pkg::POS_W-1:0] pos_y;
      logic [ddpu_pkg::ANG_W-1:0] heading;
      int errors;

      function new();
         radius = ddpu_pkg::RADIUS_RESET;
         axle = ddpu_pkg::AXLE_RESET;
         pos_x = 0;
         pos_y = 0;
         heading = 0;
         errors = 0;
      endfunction

      function longint fdiv(longint num, int sh);
         return num >>> sh;
      endfunction

      function longint rdiv(longint num, longint den);
         longint mag;
         mag = (num < 0) ? -num : num;
         mag = (mag + den / 2) / den;
         return (num < 0) ? -mag : mag;
      endfunction

      function longint clamp32(longint val);
         if (val > 64'sd2147483647) return 64'sd2147483647;
         if (val < -64'sd2147483648) return -64'sd2147483648;
         return val;
      endfunction

      function void sincos(logic [ddpu_pkg::ANG_W-1:0] ang, output longint c,
                           output longint s);
         logic [31:0] turn;
         bit flip;
         longint cx, cy, cz, xs, ys;
         turn = {ang, 16'h0000};
         flip = 0;
         if (turn >= 32'h4000_0000 && turn < 32'hC000_0000) begin
            turn = turn - 32'h8000_0000;
            flip = 1;
         end
         cz = longint'(signed'(turn));
         cx = ddpu_pkg::CORDIC_X0;
         cy = 0;
         for (int i = 0; i < ITER_COUNT; i++) begin
            xs = fdiv(cx, i);
            ys = fdiv(cy, i);
            if (cz >= 0) begin
               cx -= ys; cy += xs;
               cz -= longint'(ddpu_pkg::atan_turns(ddpu_pkg::ATAN_IDX_W'(i)));
            end else begin
               cx += ys; cy -= xs;
               cz += longint'(ddpu_pkg::atan_turns(ddpu_pkg::ATAN_IDX_W'(i)));
            end
         end
         c = flip ? -cx : cx;
         s = flip ? -cy : cy;
      endfunction

      function void note_step(logic signed [ddpu_pkg::VEL_W-1:0] vl,
                              logic signed [ddpu_pkg::VEL_W-1:0] vr,
                              logic [ddpu_pkg::MS_W-1:0] ms);
         longint q, v, c, s, den;
         logic [63:0] prod;
         logic [ddpu_pkg::ANG_W-1:0] half_turn, ang;
         pose_type p;
         den = (axle == 0) ? 1 : longint'(axle);
         q = rdiv((longint'(vr) - longint'(vl)) * longint'(ms) * longint'(radius), den);
         prod = 64'(q) * 64'(ddpu_pkg::ANGLE_K) + 64'h8000_0000;
         half_turn = prod[47:32];
         v = rdiv((longint'(vl) + longint'(vr)) * longint'(radius) * longint'(ms),
                  longint'(ddpu_pkg::DIST_DEN));
         ang = heading + half_turn;
         sincos(ang, c, s);
         pos_x = 32'(clamp32(longint'(pos_x) + fdiv(v * c + (64'sd1 << 29), 30)));
         pos_y = 32'(clamp32(longint'(pos_y) + fdiv(v * s + (64'sd1 << 29), 30)));
         heading = heading + (half_turn << 1);
         p.x = pos_x; p.y = pos_y; p.heading = heading;
         expected_poses.push_back(p);
      endfunction

      function void check_pose(pose_type got);
         pose_type e;
         if (expected_poses.size() == 0) begin
            $error("unexpected result x=%0d y=%0d heading=%0d", got.x, got.y, got.heading);
            errors++;
            return;
         end
         e = expected_poses.pop_front();
         if (got.x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, got.x); errors++;
         end
         if (got.y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, got.y); errors++;
         end
         if (got.heading !== e.heading) begin
            $error("out_heading expected %0d actual %0d", e.heading, got.heading); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [ddpu_pkg::VEL_W-1:0] req_left_velocity = 0;
   logic signed [ddpu_pkg::VEL_W-1:0] req_right_velocity = 0;
   logic [ddpu_pkg::MS_W-1:0] req_step_ms = 1;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [ddpu_pkg::POS_W-1:0] rsp_out_x;
   logic signed [ddpu_pkg::POS_W-1:0] rsp_out_y;
   logic [ddpu_pkg::ANG_W-1:0] rsp_out_heading;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   pose_scoreboard board = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off = 0;
   int cycle_count = 0;

   differential_drive_pose_update_core DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      pose_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_out_x; got.y = rsp_out_y; got.heading = rsp_out_heading;
         board.check_pose(got);
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_step(logic signed [ddpu_pkg::VEL_W-1:0] vl,
                            logic signed [ddpu_pkg::VEL_W-1:0] vr,
                            logic [ddpu_pkg::MS_W-1:0] ms);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_left_velocity <= vl;
      req_right_velocity <= vr;
      req_step_ms <= ms;
      do @(posedge clock); while (req_stall);
      board.note_step(vl, vr, ms);
   endtask

   task automatic end_burst();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      end_burst();
      while (board.expected_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [15:0] val);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= {16'h0, val};
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == ADDR_RADIUS) board.radius = val;
      else board.axle = val;
      @(posedge clock);
   endtask

   task automatic random_steps(int count);
      logic signed [ddpu_pkg::VEL_W-1:0] vl, vr;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         if (pick < 6) begin
            vl = ddpu_pkg::VEL_W'($urandom_range(4096) - 2048);
            vr = ddpu_pkg::VEL_W'(vl + $signed($urandom_range(512)) - 256);
         end else begin
            vl = ddpu_pkg::VEL_W'($urandom);
            vr = ddpu_pkg::VEL_W'($urandom);
         end
         send_step(vl, vr, (pick == 9) ? ddpu_pkg::MS_W'($urandom)
                                       : ddpu_pkg::MS_W'($urandom_range(1, 100)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_step(0, 0, 1);
      send_step(16'sh7fff, 16'sh7fff, 1023);
      send_step(-16'sh8000, -16'sh8000, 1023);
      send_step(-16'sh8000, 16'sh7fff, 1023);
      send_step(16'sh7fff, -16'sh8000, 1023);
      send_step(1024, 2048, 0);
      send_step(-1, 1, 1);
      send_step(16'sh5555, 16'shaaaa, 10'h2aa);
      send_step(16'shaaaa, 16'sh5555, 10'h155);
      for (int i = 0; i < 4; i++) send_step(16'sh7fff, 16'sh7fff, 1023);
      wait_drain();
      write_reg(ADDR_AXLE, 0);
      write_reg(ADDR_RADIUS, 16'hffff);
      send_step(100, -100, 500);
      send_step(16'sh7fff, 16'sh7fff, 1023);
      wait_drain();
      write_reg(ADDR_RADIUS, 0);
      send_step(500, 900, 300);
      wait_drain();
      write_reg(ADDR_RADIUS, 1);
      write_reg(ADDR_AXLE, 16'hffff);
      send_step(-300, 700, 1023);
      wait_drain();

      write_reg(ADDR_RADIUS, ddpu_pkg::RADIUS_RESET);
      write_reg(ADDR_AXLE, ddpu_pkg::AXLE_RESET);
      random_steps(150);
      hold_off <= 400;
      random_steps(20);
      wait_drain();

      send_idle_pct = 54;
      write_reg(ADDR_RADIUS, 16'd20000);
      write_reg(ADDR_AXLE, 16'd300);
      random_steps(140);
      wait_drain();

      send_idle_pct = 0;
      stall_pct = 54;
      write_reg(ADDR_RADIUS, 16'd500);
      write_reg(ADDR_AXLE, 16'd60000);
      random_steps(140);
      wait_drain();

      send_idle_pct = 17;
      stall_pct = 17;
      write_reg(ADDR_RADIUS, 16'd3000);
      write_reg(ADDR_AXLE, 16'd9000);
      random_steps(150);
      wait_drain();

      if (board.errors == 0 && board.expected_poses.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
